// ===== hdl/drc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants of the DDA raycast column core.
// ----------------------------------------------------------------------------
package drc_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;
	localparam int TEX_SIZE      = 64;
	localparam int MAP_SIZE      = 32;

	localparam int MAP_CELLS  = MAP_SIZE * MAP_SIZE;
	localparam int MAP_AW     = $clog2(MAP_CELLS);
	localparam int WALK_LIMIT = 2 * MAP_SIZE + 4;
	localparam int WALK_CW    = $clog2(WALK_LIMIT + 1);

	// camera = col * 2^15 / SCREEN_WIDTH by reciprocal multiply,
	// exact for every 10-bit column at this screen width
	localparam int CAM_SHIFT = 12;
	localparam int CAM_RECIP = (2**(15 + CAM_SHIFT) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;

	localparam int DVD_W = 32;
	localparam int DVS_W = 40;

	localparam logic [31:0] DELTA_SAT = 32'hFFFF_FFFF;
	localparam int PADDR_W = 5;

	// register indexes (word address)
	localparam logic [2:0] REG_POS_X      = 3'd0;
	localparam logic [2:0] REG_POS_Y      = 3'd1;
	localparam logic [2:0] REG_DIR_X      = 3'd2;
	localparam logic [2:0] REG_DIR_Y      = 3'd3;
	localparam logic [2:0] REG_PLANE_X    = 3'd4;
	localparam logic [2:0] REG_PLANE_Y    = 3'd5;
	localparam logic [2:0] REG_VIEW_PITCH = 3'd6;

	typedef struct packed {
		logic [20:0]        pos_x;
		logic [20:0]        pos_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] plane_x;
		logic signed [15:0] plane_y;
		logic signed [8:0]  view_pitch;
	} cfg_t;

	typedef struct packed {
		logic       is_cast;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic [3:0] cell_value;
		logic [9:0] column;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [9:0]         column_echo;
		logic [4:0]         hit_x;
		logic [4:0]         hit_y;
		logic               hit_side;
		logic [21:0]        wall_dist;
		logic [15:0]        line_height;
		logic [8:0]         draw_start;
		logic [8:0]         draw_end;
		logic [3:0]         tex_num;
		logic [5:0]         tex_x;
		logic [23:0]        tex_step;
		logic signed [31:0] tex_pos_start;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/dda_raycast_column_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dda_raycast_column_core
// DDA grid raycaster producing one textured wall column per cast request.
// ----------------------------------------------------------------------------
// Requests enter through a queue port (push/full). A map write stores one
// cell and returns nothing; a cast returns one result on the result port
// (empty/pop), oldest first. Camera registers sit on the APB port; the user
// must write them only while the core is idle, as the core does not enforce it.
// After reset the wall map is cleared one cell per cycle, all MAP_SIZE*MAP_SIZE
// (1024) cells, with full high until done. Register writes are taken meanwhile.
// A map write is done by the execution unit as it dequeues the request. A
// cast runs four divisions on one shared divider, plus a step and a read
// state per grid cell walked, for at most WALK_LIMIT cells.
// Two requests queue ahead of the execution unit, so requests keep being
// taken while a result waits; when the receiver stalls the finished result
// holds, the next cast waits, and requests stop once the queue is full.
// ----------------------------------------------------------------------------
module dda_raycast_column_core import drc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               req_type,
	input  wire logic [4:0]         cell_x,
	input  wire logic [4:0]         cell_y,
	input  wire logic [3:0]         cell_value,
	input  wire logic [9:0]         screen_column,
	output logic                    empty,
	input  wire logic               pop,
	output logic [9:0]              column_echo,
	output logic [4:0]              hit_x,
	output logic [4:0]              hit_y,
	output logic                    hit_side,
	output logic [21:0]             wall_dist,
	output logic [15:0]             line_height,
	output logic [8:0]              draw_start,
	output logic [8:0]              draw_end,
	output logic [3:0]              tex_num,
	output logic [5:0]              tex_x,
	output logic [23:0]             tex_step,
	output logic signed [31:0]      tex_pos_start
);

	cfg_t     cfg_q;
	item_t    head;
	logic     head_valid;
	logic     deq;
	logic     clearing;
	div_req_t div_req;
	div_rsp_t div_rsp;
	res_t     res;
	logic     res_valid;
	logic     wr_en;
	logic     res_pop;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign empty   = !res_valid;
	assign res_pop = pop && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x      <= 21'd1441792;
			cfg_q.pos_y      <= 21'd753664;
			cfg_q.dir_x      <= -16'sd16384;
			cfg_q.dir_y      <= 16'sd0;
			cfg_q.plane_x    <= 16'sd0;
			cfg_q.plane_y    <= 16'sd10813;
			cfg_q.view_pitch <= 9'sd100;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_POS_X:      cfg_q.pos_x      <= pwdata[20:0];
				REG_POS_Y:      cfg_q.pos_y      <= pwdata[20:0];
				REG_DIR_X:      cfg_q.dir_x      <= pwdata[15:0];
				REG_DIR_Y:      cfg_q.dir_y      <= pwdata[15:0];
				REG_PLANE_X:    cfg_q.plane_x    <= pwdata[15:0];
				REG_PLANE_Y:    cfg_q.plane_y    <= pwdata[15:0];
				REG_VIEW_PITCH: cfg_q.view_pitch <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_POS_X:      prdata = 32'(cfg_q.pos_x);
			REG_POS_Y:      prdata = 32'(cfg_q.pos_y);
			REG_DIR_X:      prdata = {16'd0, cfg_q.dir_x};
			REG_DIR_Y:      prdata = {16'd0, cfg_q.dir_y};
			REG_PLANE_X:    prdata = {16'd0, cfg_q.plane_x};
			REG_PLANE_Y:    prdata = {16'd0, cfg_q.plane_y};
			REG_VIEW_PITCH: prdata = {23'd0, cfg_q.view_pitch};
			default:        prdata = 32'd0;
		endcase
	end

	drc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.cell_value    (cell_value),
		.screen_column (screen_column),
		.hold          (clearing),
		.deq           (deq),
		.head          (head),
		.head_valid    (head_valid)
	);

	drc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	drc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.deq        (deq),
		.clearing   (clearing),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.res        (res),
		.res_valid  (res_valid),
		.res_pop    (res_pop)
	);

	assign column_echo   = res.column_echo;
	assign hit_x         = res.hit_x;
	assign hit_y         = res.hit_y;
	assign hit_side      = res.hit_side;
	assign wall_dist     = res.wall_dist;
	assign line_height   = res.line_height;
	assign draw_start    = res.draw_start;
	assign draw_end      = res.draw_end;
	assign tex_num       = res.tex_num;
	assign tex_x         = res.tex_x;
	assign tex_step      = res.tex_step;
	assign tex_pos_start = res.tex_pos_start;

endmodule
`default_nettype wire

// ===== hdl/drc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drc_front
// Input side: takes requests and queues them (5-bit cells are always in the map).
// ----------------------------------------------------------------------------
module drc_front import drc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic       req_type,
	input  wire logic [4:0] cell_x,
	input  wire logic [4:0] cell_y,
	input  wire logic [3:0] cell_value,
	input  wire logic [9:0] screen_column,
	input  wire logic       hold,
	input  wire logic       deq,
	output item_t           head,
	output logic            head_valid
);

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       take;
	logic       enq;
	logic       in_map;

	assign full       = hold || (cnt_q == 2'd2);
	assign take       = push && !full;
	assign in_map     = (int'(cell_x) < MAP_SIZE) && (int'(cell_y) < MAP_SIZE);
	assign enq        = take && (req_type || in_map);
	assign head       = fifo_q[rd_ptr_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq)
				wr_ptr_q <= !wr_ptr_q;
			if (deq)
				rd_ptr_q <= !rd_ptr_q;
			priority if (enq && !deq)
				cnt_q <= cnt_q + 2'd1;
			else if (deq && !enq)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_q[wr_ptr_q].is_cast    <= req_type;
			fifo_q[wr_ptr_q].cell_x     <= cell_x;
			fifo_q[wr_ptr_q].cell_y     <= cell_y;
			fifo_q[wr_ptr_q].cell_value <= cell_value;
			fifo_q[wr_ptr_q].column     <= screen_column;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> head_valid) else $error("dequeue from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== hdl/drc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drc_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drc_div import drc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);

	localparam int CW = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

// ===== hdl/drc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drc_back
// Execution side: wall map, map writes, ray setup, DDA walk, column math
// and the result register.
// ----------------------------------------------------------------------------
module drc_back import drc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  item_t     head,
	input  wire logic head_valid,
	output logic      deq,
	output logic      clearing,
	output div_req_t  div_req,
	input  div_rsp_t  div_rsp,
	output res_t      res,
	output logic      res_valid,
	input  wire logic res_pop
);

	typedef enum logic [18:0] {
		S_CLEAR  = 19'h00001,
		S_IDLE   = 19'h00002,
		S_CAM    = 19'h00004,
		S_RAY    = 19'h00008,
		S_RCPX   = 19'h00010,
		S_RCPX_W = 19'h00020,
		S_RCPY   = 19'h00040,
		S_RCPY_W = 19'h00080,
		S_SIDE   = 19'h00100,
		S_STEP   = 19'h00200,
		S_READ   = 19'h00400,
		S_PERP   = 19'h00800,
		S_LH     = 19'h01000,
		S_LH_W   = 19'h02000,
		S_SPAN   = 19'h04000,
		S_TEX    = 19'h08000,
		S_TS_W   = 19'h10000,
		S_TP     = 19'h20000,
		S_OUT    = 19'h40000
	} state_t;

	state_t state_q;

	logic [3:0]        map_mem [MAP_CELLS];
	logic [3:0]        rd_q;
	logic [MAP_AW-1:0] clr_cnt_q;
	logic              out_valid_q;
	res_t              out_q;

	logic [9:0]          col_q;
	logic signed [17:0]  cam_q;
	logic signed [18:0]  rdx_q, rdy_q;
	logic [31:0]         dlx_q, dly_q;
	logic [DVS_W-1:0]    sdx_q, sdy_q;
	logic signed [7:0]   mx_q, my_q;
	logic                side_q;
	logic [3:0]          val_q;
	logic                found_q;
	logic [WALK_CW-1:0]  cnt_q;
	logic [DVS_W-1:0]    perp_q;
	logic [15:0]         lh_q;
	logic [8:0]          ds_q, de_q;
	logic [29:0]         wp_q;
	logic [5:0]          tx_q;
	logic [23:0]         step_q;
	logic signed [42:0]  tpp_q;

	// combinational helpers
	logic [27:0]         cam_prod;
	logic [18:0]         absx, absy;
	logic signed [33:0]  prx, pry;
	logic [16:0]         fac_x, fac_y;
	logic [48:0]         px, py;
	logic                step_x;
	logic signed [7:0]   mx_n, my_n;
	logic                out_map;
	logic [MAP_AW-1:0]   rd_addr;
	logic [MAP_AW-1:0]   wr_addr;
	logic                map_we;
	logic [14:0]         half;
	logic signed [17:0]  ds_raw, de_raw, term;
	logic signed [18:0]  rd_w;
	logic [15:0]         pos_w;
	logic [15:0]         frac;
	logic [24:0]         txp;
	logic [8:0]          tx_raw;
	logic                mirror;
	logic                out_load;
	logic signed [31:0]  tp_sat;

	assign cam_prod = 28'(col_q) * 28'(CAM_RECIP);
	assign absx  = rdx_q[18] ? 19'(-rdx_q) : 19'(rdx_q);
	assign absy  = rdy_q[18] ? 19'(-rdy_q) : 19'(rdy_q);
	assign prx   = cfg.plane_x * cam_q;
	assign pry   = cfg.plane_y * cam_q;
	assign fac_x = rdx_q[18] ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
	assign fac_y = rdy_q[18] ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]};
	assign px    = 49'(fac_x) * 49'(dlx_q);
	assign py    = 49'(fac_y) * 49'(dly_q);

	// equal side distances step along y
	assign step_x  = sdx_q < sdy_q;
	assign mx_n    = step_x ? (rdx_q[18] ? mx_q - 8'sd1 : mx_q + 8'sd1) : mx_q;
	assign my_n    = step_x ? my_q : (rdy_q[18] ? my_q - 8'sd1 : my_q + 8'sd1);
	assign out_map = (mx_n < 8'sd0) || (my_n < 8'sd0) ||
		(int'(mx_n) >= MAP_SIZE) || (int'(my_n) >= MAP_SIZE);
	assign rd_addr = MAP_AW'(int'(my_n) * MAP_SIZE + int'(mx_n));
	assign wr_addr = MAP_AW'(int'(head.cell_y) * MAP_SIZE + int'(head.cell_x));
	assign map_we  = (state_q == S_IDLE) && head_valid && !head.is_cast;

	assign half   = lh_q[15:1];
	assign ds_raw = 18'sd0 - 18'(half) + 18'(SCREEN_HEIGHT / 2) + 18'(cfg.view_pitch);
	assign de_raw = 18'(half) + 18'(SCREEN_HEIGHT / 2) + 18'(cfg.view_pitch);
	assign term   = 18'(ds_q) - 18'(cfg.view_pitch) - 18'(SCREEN_HEIGHT / 2) + 18'(half);

	// only the low 16 bits of the wall position matter
	assign rd_w   = side_q ? rdx_q : rdy_q;
	assign pos_w  = side_q ? cfg.pos_x[15:0] : cfg.pos_y[15:0];
	assign frac   = pos_w + wp_q[29:14];
	assign txp    = 25'(frac) * 25'(TEX_SIZE);
	assign tx_raw = txp[24:16];
	assign mirror = (!side_q && !rdx_q[18] && (rdx_q != 19'sd0)) || (side_q && rdy_q[18]);

	assign tp_sat = (tpp_q > 43'sd2147483647) ? 32'sh7FFF_FFFF :
		(tpp_q < -43'sd2147483648) ? 32'sh8000_0000 : tpp_q[31:0];

	assign out_load  = (state_q == S_OUT) && (!out_valid_q || res_pop);
	assign deq       = (state_q == S_IDLE) && head_valid;
	assign clearing  = (state_q == S_CLEAR);
	assign res       = out_q;
	assign res_valid = out_valid_q;

	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_RCPX: begin
				div_req.start    = 1'b1;
				div_req.dividend = 32'h4000_0000;
				div_req.divisor  = DVS_W'(absx);
			end
			S_RCPY: begin
				div_req.start    = 1'b1;
				div_req.dividend = 32'h4000_0000;
				div_req.divisor  = DVS_W'(absy);
			end
			S_LH: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(SCREEN_HEIGHT * 65536);
				div_req.divisor  = perp_q;
			end
			S_TEX: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(TEX_SIZE * 65536);
				div_req.divisor  = DVS_W'(lh_q);
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (res_pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
					if (clr_cnt_q == MAP_AW'(MAP_CELLS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE:   if (head_valid && head.is_cast) state_q <= S_CAM;
				S_CAM:    state_q <= S_RAY;
				S_RAY:    state_q <= S_RCPX;
				S_RCPX:   state_q <= S_RCPX_W;
				S_RCPX_W: if (div_rsp.done) state_q <= S_RCPY;
				S_RCPY:   state_q <= S_RCPY_W;
				S_RCPY_W: if (div_rsp.done) state_q <= S_SIDE;
				S_SIDE:   state_q <= S_STEP;
				S_STEP:   state_q <= out_map ? S_PERP : S_READ;
				S_READ: begin
					if (rd_q != 4'd0 || cnt_q == WALK_CW'(WALK_LIMIT - 1))
						state_q <= S_PERP;
					else
						state_q <= S_STEP;
				end
				S_PERP:   state_q <= S_LH;
				S_LH:     state_q <= S_LH_W;
				S_LH_W:   if (div_rsp.done) state_q <= S_SPAN;
				S_SPAN:   state_q <= S_TEX;
				S_TEX:    state_q <= S_TS_W;
				S_TS_W:   if (div_rsp.done) state_q <= S_TP;
				S_TP:     state_q <= S_OUT;
				S_OUT:    if (out_load) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: col_q <= head.column;
			S_CAM: cam_q <= $signed({2'b00, cam_prod[27:CAM_SHIFT]}) - 18'sd16384;
			S_RAY: begin
				rdx_q <= 19'(20'(cfg.dir_x) + 20'(prx >>> 14));
				rdy_q <= 19'(20'(cfg.dir_y) + 20'(pry >>> 14));
			end
			S_RCPX_W: dlx_q <= (absx == 19'd0) ? DELTA_SAT : div_rsp.quotient;
			S_RCPY_W: dly_q <= (absy == 19'd0) ? DELTA_SAT : div_rsp.quotient;
			S_SIDE: begin
				sdx_q   <= DVS_W'(px >> 16);
				sdy_q   <= DVS_W'(py >> 16);
				mx_q    <= 8'(cfg.pos_x[20:16]);
				my_q    <= 8'(cfg.pos_y[20:16]);
				side_q  <= 1'b0;
				found_q <= 1'b0;
				val_q   <= 4'd0;
				cnt_q   <= '0;
			end
			S_STEP: begin
				if (step_x) sdx_q <= sdx_q + DVS_W'(dlx_q);
				else        sdy_q <= sdy_q + DVS_W'(dly_q);
				mx_q   <= mx_n;
				my_q   <= my_n;
				side_q <= !step_x;
			end
			S_READ: begin
				cnt_q <= cnt_q + WALK_CW'(1);
				if (rd_q != 4'd0) begin
					found_q <= 1'b1;
					val_q   <= rd_q;
				end
			end
			S_PERP: perp_q <= side_q ? sdy_q - DVS_W'(dly_q) : sdx_q - DVS_W'(dlx_q);
			S_LH_W: begin
				if (perp_q == '0 || div_rsp.quotient > 32'd65535)
					lh_q <= 16'hFFFF;
				else
					lh_q <= div_rsp.quotient[15:0];
			end
			S_SPAN: begin
				ds_q <= (ds_raw < 18'sd0) ? 9'd0 :
					(ds_raw > 18'(SCREEN_HEIGHT - 1)) ? 9'(SCREEN_HEIGHT - 1) : ds_raw[8:0];
				de_q <= (de_raw < 18'sd0) ? 9'd0 :
					(de_raw > 18'(SCREEN_HEIGHT - 1)) ? 9'(SCREEN_HEIGHT - 1) : de_raw[8:0];
				wp_q <= perp_q[29:0] * 30'(rd_w);
			end
			S_TEX: tx_q <= mirror ? 6'(9'(TEX_SIZE - 1) - tx_raw) : tx_raw[5:0];
			S_TS_W: begin
				if (lh_q == 16'd0 || div_rsp.quotient > 32'h00FF_FFFF)
					step_q <= 24'hFF_FFFF;
				else
					step_q <= div_rsp.quotient[23:0];
			end
			S_TP: tpp_q <= term * $signed({1'b0, step_q});
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.column_echo   <= col_q;
			out_q.hit_x         <= mx_q[4:0];
			out_q.hit_y         <= my_q[4:0];
			out_q.hit_side      <= side_q;
			out_q.wall_dist     <= (perp_q > DVS_W'(4194303)) ? 22'h3F_FFFF : perp_q[21:0];
			out_q.line_height   <= lh_q;
			out_q.draw_start    <= ds_q;
			out_q.draw_end      <= de_q;
			out_q.tex_num       <= found_q ? val_q - 4'd1 : 4'd0;
			out_q.tex_x         <= tx_q;
			out_q.tex_step      <= step_q;
			out_q.tex_pos_start <= tp_sat;
		end
	end

	// wall map
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			map_mem[clr_cnt_q] <= 4'd0;
		else if (map_we)
			map_mem[wr_addr] <= head.cell_value;
		rd_q <= map_mem[rd_addr];
	end

`ifndef NO_ASSERTIONS
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		map_we |-> head_valid && deq) else $error("map write without dequeue");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && !res_pop) |=> state_q == S_OUT)
		else $error("result overwritten");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_RCPX_W ||
		state_q == S_RCPY_W || state_q == S_LH_W || state_q == S_TS_W))
		else $error("divider result not awaited");
`endif

endmodule
`default_nettype wire
